// ----- design/hcbd_pkg.sv -----
// ----------------------------------------------------------------------------
// HTTP chunked body decoder package
// Shared types, codes and constants of the body decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

  localparam int unsigned MaxPayloadDefault = 256;
  localparam int unsigned MaxChunksDefault  = 64;

  // Depth of the queue between front and back, and of the result queue.
  localparam int unsigned MidQueueDepth = 2;
  localparam int unsigned OutQueueDepth = 2;

  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth  = 9;

  localparam logic [CfgIndexWidth-1:0] CFG_CHUNKED_MODE = 2'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_PLAIN_LENGTH = 2'd1;

  localparam logic [8:0] PLAIN_LENGTH_RESET = 9'd256;

  // Trailer bytes swallowed after the data of a chunk, at most.
  localparam logic [1:0] TRAILER_MAX = 2'd2;

  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_SEMI = 8'h3B;

  typedef enum logic [1:0] {
    CMD_DATA  = 2'd0,
    CMD_EOS   = 2'd1,
    CMD_START = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    PH_SIZE    = 2'd0,
    PH_DATA    = 2'd1,
    PH_TRAILER = 2'd2,
    PH_DONE    = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    CAUSE_RUN   = 3'd0,
    CAUSE_EMPTY = 3'd1,
    CAUSE_EOS   = 3'd2,
    CAUSE_BAD   = 3'd3,
    CAUSE_LIMIT = 3'd4
  } cause_e;

  // A classified input item, as it travels from front to back.
  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] data;
    logic       is_lf;
    logic       is_cr;
    logic       is_semi;
    logic       hex_ok;
    logic [3:0] hex_val;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       body_done;
    logic [8:0] body_length;
    cause_e     end_cause;
  } result_t;

endpackage

// ----- design/http_chunked_body_decoder.sv -----
// A taken byte is written into the item queue; the parser then takes it from
// there and writes its result into the result queue, once that queue has room.
// Throughput: one byte per clock while neither queue stalls; the parser handles
// a whole byte at once. Each side stalls on its own behind a two-entry queue.
// Reset clears all body state, empties both queues and sets the registers to
// raw mode with a plain length of 256.
// ----------------------------------------------------------------------------
// HTTP chunked body decoder
// Strips chunked framing from a body, or caps a raw one; keeps payload bytes.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder import hcbd_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = MaxPayloadDefault,
  parameter int unsigned MAX_CHUNKS  = MaxChunksDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push,
  output logic                     full,
  input  logic [1:0]               command_i,
  input  logic [7:0]               data_byte_i,
  output logic                     empty,
  input  logic                     pop,
  output logic [7:0]               out_byte_o,
  output logic                     out_valid_o,
  output logic                     body_done_o,
  output logic [8:0]               body_length_o,
  output logic [2:0]               end_cause_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIndexWidth-1:0] cfg_index_i,
  input  logic [CfgDataWidth-1:0]  cfg_data_i
);

  logic       chunked_mode_q, chunked_mode_d;
  logic [8:0] plain_length_q, plain_length_d;

  logic    mid_push, mid_full, mid_pop, mid_empty;
  item_t   mid_wdata, mid_rdata;
  logic    res_push, res_full;
  result_t res_wdata, res_rdata;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    chunked_mode_d = chunked_mode_q;
    plain_length_d = plain_length_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_CHUNKED_MODE: chunked_mode_d = cfg_data_i[0];
        CFG_PLAIN_LENGTH: plain_length_d = cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunked_mode_q <= 1'b0;
      plain_length_q <= PLAIN_LENGTH_RESET;
    end else begin
      chunked_mode_q <= chunked_mode_d;
      plain_length_q <= plain_length_d;
    end
  end

  hcbd_front u_front (
    .push_i      (push),
    .command_i   (command_i),
    .data_byte_i (data_byte_i),
    .full_o      (full),
    .mid_full_i  (mid_full),
    .mid_push_o  (mid_push),
    .mid_item_o  (mid_wdata)
  );

  hcbd_fifo #(
    .WIDTH ($bits(item_t)),
    .DEPTH (MidQueueDepth)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .wdata_i (mid_wdata),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .rdata_o (mid_rdata),
    .empty_o (mid_empty)
  );

  hcbd_back #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .MAX_CHUNKS  (MAX_CHUNKS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .chunked_mode_i (chunked_mode_q),
    .plain_length_i (plain_length_q),
    .item_i         (mid_rdata),
    .item_empty_i   (mid_empty),
    .item_pop_o     (mid_pop),
    .res_full_i     (res_full),
    .res_push_o     (res_push),
    .res_o          (res_wdata)
  );

  hcbd_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OutQueueDepth)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_wdata),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_rdata),
    .empty_o (empty)
  );

  assign out_byte_o    = res_rdata.out_byte;
  assign out_valid_o   = res_rdata.out_valid;
  assign body_done_o   = res_rdata.body_done;
  assign body_length_o = res_rdata.body_length;
  assign end_cause_o   = res_rdata.end_cause;

endmodule

// ----- design/hcbd_fifo.sv -----
// ----------------------------------------------------------------------------
// HTTP chunked body decoder queue
// Small first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
module hcbd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW:0]      wr_ptr_q, wr_ptr_d;
  logic [AW:0]      rd_ptr_q, rd_ptr_d;
  logic             do_push, do_pop;

  assign empty_o = (wr_ptr_q == rd_ptr_q);
  assign full_o  = (wr_ptr_q[AW] != rd_ptr_q[AW]) &&
                   (wr_ptr_q[AW-1:0] == rd_ptr_q[AW-1:0]);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
  assign rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
  assign rdata_o  = mem_q[rd_ptr_q[AW-1:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q[AW-1:0]] <= wdata_i;
    end
  end

endmodule

// ----- design/hcbd_front.sv -----
// ----------------------------------------------------------------------------
// HTTP chunked body decoder front
// Accepts input items and classifies the byte for the size line parser.
// ----------------------------------------------------------------------------
module hcbd_front import hcbd_pkg::*; (
  input  logic       push_i,
  input  logic [1:0] command_i,
  input  logic [7:0] data_byte_i,
  output logic       full_o,
  input  logic       mid_full_i,
  output logic       mid_push_o,
  output item_t      mid_item_o
);

  always_comb begin
    mid_item_o         = '0;
    mid_item_o.cmd     = cmd_e'(command_i);
    mid_item_o.data    = data_byte_i;
    mid_item_o.is_lf   = (data_byte_i == CHAR_LF);
    mid_item_o.is_cr   = (data_byte_i == CHAR_CR);
    mid_item_o.is_semi = (data_byte_i == CHAR_SEMI);
    // Hex digits in either letter case.
    if (data_byte_i inside {["0":"9"]}) begin
      mid_item_o.hex_ok  = 1'b1;
      mid_item_o.hex_val = data_byte_i[3:0];
    end else if (data_byte_i inside {["a":"f"], ["A":"F"]}) begin
      mid_item_o.hex_ok  = 1'b1;
      mid_item_o.hex_val = data_byte_i[3:0] + 4'd9;
    end else begin
      mid_item_o.hex_ok  = 1'b0;
      mid_item_o.hex_val = 4'd0;
    end
  end

  assign full_o     = mid_full_i;
  assign mid_push_o = push_i && !mid_full_i;

endmodule

// ----- design/hcbd_back.sv -----
// ----------------------------------------------------------------------------
// HTTP chunked body decoder back
// Runs the body state machine on classified items and forms one result each.
// ----------------------------------------------------------------------------
module hcbd_back import hcbd_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = MaxPayloadDefault,
  parameter int unsigned MAX_CHUNKS  = MaxChunksDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       chunked_mode_i,
  input  logic [8:0] plain_length_i,
  input  item_t      item_i,
  input  logic       item_empty_i,
  output logic       item_pop_o,
  input  logic       res_full_i,
  output logic       res_push_o,
  output result_t    res_o
);

  localparam int unsigned KW = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned CW = $clog2(MAX_CHUNKS + 1);
  localparam int unsigned LW = (KW > 9) ? KW : 9;

  localparam logic [KW-1:0] KeptCap  = KW'(MAX_PAYLOAD);
  localparam logic [LW-1:0] LimitCap = LW'(MAX_PAYLOAD);
  localparam logic [CW-1:0] ChunkCap = CW'(MAX_CHUNKS);

  phase_e        phase_q, phase_d;
  logic          in_ext_q, in_ext_d;
  logic          saw_hex_q, saw_hex_d;
  logic [31:0]   acc_q, acc_d;
  logic [31:0]   left_q, left_d;
  logic [1:0]    trl_q, trl_d;
  logic [CW-1:0] chunk_q, chunk_d;
  logic [KW-1:0] kept_q, kept_d;
  cause_e        cause_q, cause_d;
  logic          kept_flag;

  logic          fire;
  logic          kept_full;
  logic [KW-1:0] kept_inc;
  logic [CW-1:0] chunk_inc;
  logic [1:0]    trl_inc;
  logic [LW-1:0] plain_ext, limit, kept_ext, kept_inc_ext, kept_next_ext;

  assign fire       = !item_empty_i && !res_full_i;
  assign item_pop_o = fire;
  assign res_push_o = fire;

  assign kept_full     = (kept_q >= KeptCap);
  assign kept_inc      = kept_q + KW'(1);
  assign chunk_inc     = chunk_q + CW'(1);
  assign trl_inc       = trl_q + 2'd1;
  assign plain_ext     = LW'(plain_length_i);
  assign limit         = (plain_ext > LimitCap) ? LimitCap : plain_ext;
  assign kept_ext      = LW'(kept_q);
  assign kept_inc_ext  = LW'(kept_inc);
  assign kept_next_ext = LW'(kept_d);

  // Next state.
  always_comb begin
    phase_d   = phase_q;
    in_ext_d  = in_ext_q;
    saw_hex_d = saw_hex_q;
    acc_d     = acc_q;
    left_d    = left_q;
    trl_d     = trl_q;
    chunk_d   = chunk_q;
    kept_d    = kept_q;
    cause_d   = cause_q;
    kept_flag = 1'b0;
    if (fire) begin
      case (item_i.cmd)
        CMD_START: begin
          phase_d   = PH_SIZE;
          in_ext_d  = 1'b0;
          saw_hex_d = 1'b0;
          acc_d     = '0;
          left_d    = '0;
          trl_d     = '0;
          chunk_d   = '0;
          kept_d    = '0;
          cause_d   = CAUSE_RUN;
        end
        CMD_EOS: begin
          if (phase_q != PH_DONE) begin
            phase_d = PH_DONE;
            cause_d = CAUSE_EOS;
          end
        end
        CMD_DATA: begin
          if (phase_q != PH_DONE && chunked_mode_i) begin
            case (phase_q)
              PH_SIZE: begin
                if (item_i.is_lf) begin
                  if (!saw_hex_q || acc_q == '0) begin
                    phase_d = PH_DONE;
                    cause_d = CAUSE_EMPTY;
                  end else begin
                    left_d  = acc_q;
                    phase_d = PH_DATA;
                    if (kept_full) begin
                      phase_d = PH_DONE;
                      cause_d = CAUSE_LIMIT;
                    end
                  end
                end else if (item_i.is_cr || in_ext_q) begin
                  // Carriage returns and extension text are dropped.
                end else if (item_i.is_semi) begin
                  in_ext_d = 1'b1;
                end else if (!item_i.hex_ok || acc_q[31:28] != 4'd0) begin
                  // A nonzero top digit means one more digit would overflow.
                  phase_d = PH_DONE;
                  cause_d = CAUSE_BAD;
                end else begin
                  acc_d     = {acc_q[27:0], item_i.hex_val};
                  saw_hex_d = 1'b1;
                end
              end
              PH_DATA: begin
                if (kept_full || left_q == '0) begin
                  phase_d = PH_DONE;
                  cause_d = CAUSE_LIMIT;
                end else begin
                  kept_flag = 1'b1;
                  kept_d    = kept_inc;
                  left_d    = left_q - 32'd1;
                  if (left_q == 32'd1) begin
                    phase_d = PH_TRAILER;
                    trl_d   = '0;
                  end else if (kept_inc >= KeptCap) begin
                    phase_d = PH_DONE;
                    cause_d = CAUSE_LIMIT;
                  end
                end
              end
              PH_TRAILER: begin
                trl_d = trl_inc;
                if (item_i.is_lf || trl_inc >= TRAILER_MAX) begin
                  chunk_d = chunk_inc;
                  if (chunk_inc >= ChunkCap) begin
                    phase_d = PH_DONE;
                    cause_d = CAUSE_LIMIT;
                  end else begin
                    phase_d   = PH_SIZE;
                    in_ext_d  = 1'b0;
                    saw_hex_d = 1'b0;
                    acc_d     = '0;
                    trl_d     = '0;
                  end
                end
              end
              default: ;
            endcase
          end else if (phase_q != PH_DONE) begin
            if (kept_ext >= limit) begin
              phase_d = PH_DONE;
              cause_d = CAUSE_LIMIT;
            end else begin
              kept_flag = 1'b1;
              kept_d    = kept_inc;
              if (kept_inc_ext >= limit) begin
                phase_d = PH_DONE;
                cause_d = CAUSE_LIMIT;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Result of the item handled this cycle.
  always_comb begin
    res_o             = '0;
    res_o.out_byte    = kept_flag ? item_i.data : 8'd0;
    res_o.out_valid   = kept_flag;
    res_o.body_done   = (phase_d == PH_DONE);
    res_o.body_length = kept_next_ext[8:0];
    res_o.end_cause   = cause_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_SIZE;
      in_ext_q  <= 1'b0;
      saw_hex_q <= 1'b0;
      acc_q     <= '0;
      left_q    <= '0;
      trl_q     <= '0;
      chunk_q   <= '0;
      kept_q    <= '0;
      cause_q   <= CAUSE_RUN;
    end else begin
      phase_q   <= phase_d;
      in_ext_q  <= in_ext_d;
      saw_hex_q <= saw_hex_d;
      acc_q     <= acc_d;
      left_q    <= left_d;
      trl_q     <= trl_d;
      chunk_q   <= chunk_d;
      kept_q    <= kept_d;
      cause_q   <= cause_d;
    end
  end

endmodule

// ----- verif/http_chunked_body_decoder_tb.sv -----
// ----------------------------------------------------------------------------
// HTTP chunked body decoder testbench
// Feeds response bodies, some framed and some raw, byte by byte through the
// push side, drains the results with random stalls, and checks every result
// against a cycle-free model of the decoder kept inside this bench.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_tb;
  import hcbd_pkg::*;

  localparam int unsigned PayloadCap   = MaxPayloadDefault;
  localparam int unsigned ChunkCap     = MaxChunksDefault;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned PhaseCount   = 10;
  localparam int unsigned PhaseTarget  = 85;
  localparam int unsigned RunLimit     = 5_000_000;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] data;
  } stim_t;

  logic                     clk_i;
  logic                     rst_ni       = 1'b0;
  logic                     push         = 1'b0;
  logic                     full;
  logic [1:0]               command_i    = CMD_DATA;
  logic [7:0]               data_byte_i  = 8'h00;
  logic                     empty;
  logic                     pop          = 1'b0;
  logic [7:0]               out_byte_o;
  logic                     out_valid_o;
  logic                     body_done_o;
  logic [8:0]               body_length_o;
  logic [2:0]               end_cause_o;
  logic                     cfg_valid_i  = 1'b0;
  logic                     cfg_ready_o;
  logic [CfgIndexWidth-1:0] cfg_index_i  = CFG_CHUNKED_MODE;
  logic [CfgDataWidth-1:0]  cfg_data_i   = '0;

  // Handshake bookkeeping, sampled at the rising edge.
  logic in_taken  = 1'b0;
  logic out_taken = 1'b0;

  stim_t   byte_feed[$];
  result_t pending_results[$];

  bit          idle_on = 1'b0;
  bit          hold_go = 1'b0;
  bit          rx_hold = 1'b0;
  int unsigned send_wait = 0;
  int unsigned recv_wait = 0;

  int unsigned errors       = 0;
  int unsigned items_in     = 0;
  int unsigned results_seen = 0;
  int unsigned bytes_kept   = 0;
  int unsigned full_cycles  = 0;
  int unsigned cfg_writes   = 0;
  int unsigned cause_hits[0:4];

  // Decoder model state and its copy of the registers.
  bit          chunked_cfg;
  logic [8:0]  plain_len_cfg;
  phase_e      ph;
  bit          in_ext;
  bit          saw_hex;
  logic [31:0] size_acc;
  logic [31:0] left;
  int unsigned trl_cnt;
  int unsigned chunks_done;
  int unsigned kept_cnt;
  cause_e      end_why;

  http_chunked_body_decoder #(
    .MAX_PAYLOAD(PayloadCap),
    .MAX_CHUNKS (ChunkCap)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .command_i    (command_i),
    .data_byte_i  (data_byte_i),
    .empty        (empty),
    .pop          (pop),
    .out_byte_o   (out_byte_o),
    .out_valid_o  (out_valid_o),
    .body_done_o  (body_done_o),
    .body_length_o(body_length_o),
    .end_cause_o  (end_cause_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Decoder model
  // ---------------------------------------------------------------------------
  function automatic void clear_body();
    ph          = PH_SIZE;
    in_ext      = 1'b0;
    saw_hex     = 1'b0;
    size_acc    = '0;
    left        = '0;
    trl_cnt     = 0;
    chunks_done = 0;
    kept_cnt    = 0;
    end_why     = CAUSE_RUN;
  endfunction

  function automatic void end_body(cause_e why);
    ph      = PH_DONE;
    end_why = why;
  endfunction

  function automatic int hex_digit(logic [7:0] b);
    if (b >= 8'h30 && b <= 8'h39) return int'(b) - 'h30;
    if (b >= 8'h61 && b <= 8'h66) return int'(b) - 'h61 + 10;
    if (b >= 8'h41 && b <= 8'h46) return int'(b) - 'h41 + 10;
    return -1;
  endfunction

  function automatic bit chunked_step(logic [7:0] b);
    int d;
    bit keep;
    keep = 1'b0;
    d    = hex_digit(b);
    case (ph)
      PH_SIZE: begin
        if (b == CHAR_LF) begin
          if (!saw_hex || size_acc == 0) begin
            end_body(CAUSE_EMPTY);
          end else begin
            left = size_acc;
            ph   = PH_DATA;
            // No room left for the data this size line announces.
            if (kept_cnt >= PayloadCap) end_body(CAUSE_LIMIT);
          end
        end else if (b == CHAR_CR || in_ext) begin
          // CR and extension text are skipped.
        end else if (b == CHAR_SEMI) begin
          in_ext = 1'b1;
        end else if (d < 0) begin
          end_body(CAUSE_BAD);
        end else if (size_acc > (32'hFFFF_FFFF - 32'(d)) / 32'd16) begin
          end_body(CAUSE_BAD);
        end else begin
          size_acc = size_acc * 32'd16 + 32'(d);
          saw_hex  = 1'b1;
        end
      end
      PH_DATA: begin
        if (kept_cnt >= PayloadCap || left == 0) begin
          end_body(CAUSE_LIMIT);
        end else begin
          keep = 1'b1;
          kept_cnt++;
          left--;
          if (left == 0) begin
            ph      = PH_TRAILER;
            trl_cnt = 0;
          end else if (kept_cnt >= PayloadCap) begin
            end_body(CAUSE_LIMIT);
          end
        end
      end
      PH_TRAILER: begin
        trl_cnt++;
        if (b == CHAR_LF || trl_cnt >= TRAILER_MAX) begin
          chunks_done++;
          if (chunks_done >= ChunkCap) begin
            end_body(CAUSE_LIMIT);
          end else begin
            ph       = PH_SIZE;
            in_ext   = 1'b0;
            saw_hex  = 1'b0;
            size_acc = '0;
            trl_cnt  = 0;
          end
        end
      end
      default: begin
      end
    endcase
    return keep;
  endfunction

  function automatic bit plain_step();
    int unsigned cap;
    cap = (plain_len_cfg > PayloadCap) ? PayloadCap : plain_len_cfg;
    if (kept_cnt >= cap) begin
      end_body(CAUSE_LIMIT);
      return 1'b0;
    end
    kept_cnt++;
    if (kept_cnt >= cap) end_body(CAUSE_LIMIT);
    return 1'b1;
  endfunction

  function automatic result_t decode_step(cmd_e c, logic [7:0] b);
    result_t r;
    bit      keep;
    cause_e  was;
    keep = 1'b0;
    was  = end_why;
    case (c)
      CMD_START: clear_body();
      CMD_EOS:   if (ph != PH_DONE) end_body(CAUSE_EOS);
      CMD_DATA:  if (ph != PH_DONE) keep = chunked_cfg ? chunked_step(b) : plain_step();
      default: begin
      end
    endcase
    if (was == CAUSE_RUN && end_why != CAUSE_RUN) cause_hits[end_why]++;
    if (keep) bytes_kept++;
    r.out_byte    = keep ? b : 8'h00;
    r.out_valid   = keep;
    r.body_done   = (ph == PH_DONE);
    r.body_length = kept_cnt[8:0];
    r.end_cause   = end_why;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void add_item(cmd_e c, logic [7:0] b);
    byte_feed.push_back('{cmd: c, data: b});
  endfunction

  // Framing bytes are occasionally corrupted to exercise broken bodies.
  function automatic void add_frame(logic [7:0] b);
    if ($urandom_range(0, 199) == 0) b = 8'($urandom);
    add_item(CMD_DATA, b);
  endfunction

  // ASCII digit, or a letter in a random case.
  function automatic logic [7:0] hex_char(logic [3:0] nib);
    if (nib < 10) return 8'h30 + 8'(nib);
    return (($urandom_range(0, 1) != 0) ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
  endfunction

  function automatic void emit_size(int unsigned size);
    int n;
    n = 1;
    while (n < 8 && (size >> (4 * n)) != 0) n++;
    if ($urandom_range(0, 4) == 0) add_frame(8'h30);
    for (int i = n - 1; i >= 0; i--) add_frame(hex_char(4'((size >> (4 * i)) & 15)));
  endfunction

  function automatic void add_chunked_body(bit lead_start);
    int unsigned roll;
    int unsigned size;
    if (lead_start) add_item(CMD_START, 8'($urandom));
    repeat ($urandom_range(1, 5)) begin
      roll = $urandom_range(0, 99);
      if (roll < 80)      size = $urandom_range(1, 16);
      else if (roll < 95) size = $urandom_range(17, 64);
      else                size = $urandom_range(100, 300);
      if ($urandom_range(0, 49) == 0) begin
        // Too many digits for a 32-bit size.
        add_frame(hex_char(4'($urandom_range(1, 15))));
        repeat ($urandom_range(8, 9)) add_frame(hex_char(4'($urandom_range(0, 15))));
      end else begin
        emit_size(size);
      end
      if ($urandom_range(0, 4) == 0) begin
        add_frame(CHAR_SEMI);
        repeat ($urandom_range(0, 4)) add_frame(8'($urandom_range(8'h20, 8'h7E)));
      end
      if ($urandom_range(0, 4) != 0) add_frame(CHAR_CR);
      add_frame(CHAR_LF);
      repeat (size) add_item(CMD_DATA, 8'($urandom));
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        add_frame(CHAR_CR);
        add_frame(CHAR_LF);
      end else if (roll < 85) begin
        add_frame(CHAR_LF);
      end else begin
        add_item(CMD_DATA, 8'($urandom));
        add_item(CMD_DATA, 8'($urandom));
      end
    end
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      add_frame(8'h30);
      if ($urandom_range(0, 1) != 0) add_frame(CHAR_CR);
      add_frame(CHAR_LF);
      add_frame(CHAR_CR);
      add_frame(CHAR_LF);
    end else if (roll < 75) begin
      add_frame(CHAR_CR);
      add_frame(CHAR_LF);
    end else if (roll < 85) begin
      add_item(CMD_EOS, 8'($urandom));
    end else if (roll < 95) begin
      add_item(CMD_DATA, 8'h78);
    end
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 2)) add_item(CMD_DATA, 8'($urandom));
    end
  endfunction

  function automatic void add_plain_run(bit lead_start);
    int unsigned roll;
    if (lead_start) add_item(CMD_START, 8'($urandom));
    repeat ($urandom_range(60, 130)) begin
      roll = $urandom_range(0, 99);
      if (roll < 3)      add_item(CMD_EOS, 8'($urandom));
      else if (roll < 6) add_item(CMD_NONE, 8'($urandom));
      else if (roll < 9) add_item(CMD_START, 8'($urandom));
      else               add_item(CMD_DATA, 8'($urandom));
    end
  endfunction

  function automatic int unsigned idle_gap();
    int unsigned roll;
    if (!idle_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 20);
  endfunction

  function automatic void flag_error(string msg);
    errors++;
    if (errors <= 10) $display("ERROR: %s", msg);
  endfunction

  task automatic write_reg(logic [CfgIndexWidth-1:0] idx, logic [CfgDataWidth-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_CHUNKED_MODE) chunked_cfg = val[0];
    else if (idx == CFG_PLAIN_LENGTH) plain_len_cfg = val;
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Returns once every item is taken, every result checked and the pipe is quiet.
  task automatic drain();
    while (byte_feed.size() != 0 || push || pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Driver, receiver and monitor
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    stim_t nxt;
    if (!rst_ni) begin
      push <= 1'b0;
    end else if (!push || in_taken) begin
      if (send_wait > 0) begin
        send_wait--;
        push <= 1'b0;
      end else if (byte_feed.size() > 0) begin
        nxt = byte_feed.pop_front();
        command_i   <= nxt.cmd;
        data_byte_i <= nxt.data;
        push        <= 1'b1;
        send_wait = idle_gap();
      end else begin
        push <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni || rx_hold) begin
      pop <= 1'b0;
    end else if (recv_wait > 0) begin
      recv_wait--;
      pop <= 1'b0;
    end else if (pop && out_taken) begin
      recv_wait = idle_gap();
      pop <= (recv_wait == 0);
    end else begin
      pop <= 1'b1;
    end
  end

  // The long hold-off lets the block fill up while the sender keeps pushing.
  initial begin
    wait (hold_go);
    @(posedge clk_i);
    rx_hold = 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    rx_hold = 1'b0;
  end

  always @(posedge clk_i) begin
    result_t want;
    if (!rst_ni) begin
      in_taken  <= 1'b0;
      out_taken <= 1'b0;
    end else begin
      in_taken  <= push && !full;
      out_taken <= pop && !empty;
      if (push && full) full_cycles++;
      if (push && !full) begin
        pending_results.push_back(decode_step(cmd_e'(command_i), data_byte_i));
        items_in++;
      end
      if (pop && !empty) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          flag_error($sformatf("unexpected result byte=%02h valid=%0d done=%0d len=%0d cause=%0d",
                               out_byte_o, out_valid_o, body_done_o, body_length_o,
                               end_cause_o));
        end else begin
          want = pending_results.pop_front();
          if (out_byte_o !== want.out_byte || out_valid_o !== want.out_valid ||
              body_done_o !== want.body_done || body_length_o !== want.body_length ||
              end_cause_o !== want.end_cause) begin
            flag_error($sformatf({"result %0d: expected byte=%02h valid=%0d done=%0d len=%0d ",
                                  "cause=%0d, got byte=%02h valid=%0d done=%0d len=%0d cause=%0d"},
                                 results_seen, want.out_byte, want.out_valid, want.body_done,
                                 want.body_length, want.end_cause, out_byte_o, out_valid_o,
                                 body_done_o, body_length_o, end_cause_o));
          end
        end
      end
    end
  end

  initial begin
    #(RunLimit);
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    bit         mode_sel;
    logic [8:0] len_sel;
    foreach (cause_hits[i]) cause_hits[i] = 0;
    chunked_cfg   = 1'b0;
    plain_len_cfg = PLAIN_LENGTH_RESET;
    clear_body();

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed framing cases in chunked mode.
    write_reg(CFG_CHUNKED_MODE, 9'd1);
    write_reg(CFG_PLAIN_LENGTH, 9'd256);
    @(posedge clk_i);
    idle_on = 1'b1;
    add_item(CMD_START, 8'hFF);
    add_item(CMD_DATA, 8'h32);            // size 2
    add_item(CMD_DATA, CHAR_SEMI);        // extension with a non-hex character
    add_item(CMD_DATA, 8'h71);
    add_item(CMD_DATA, CHAR_CR);
    add_item(CMD_DATA, CHAR_LF);
    add_item(CMD_DATA, 8'h00);
    add_item(CMD_DATA, 8'hFF);
    add_item(CMD_DATA, 8'h58);            // two trailer bytes without LF
    add_item(CMD_DATA, 8'h59);
    add_item(CMD_DATA, CHAR_LF);          // empty size line ends the body
    add_item(CMD_DATA, 8'h41);            // ignored after the end
    add_item(CMD_NONE, 8'hAA);
    add_item(CMD_EOS, 8'h55);             // stream end on an ended body
    add_item(CMD_START, 8'h00);
    repeat (8) add_item(CMD_DATA, 8'h66); // lower case digits, then overflow
    add_item(CMD_DATA, 8'h46);
    add_item(CMD_START, 8'h00);
    add_item(CMD_DATA, 8'h67);            // malformed digit
    add_item(CMD_START, 8'h00);
    add_item(CMD_DATA, 8'h31);
    add_item(CMD_EOS, 8'h00);
    drain();

    for (int unsigned p = 0; p < PhaseCount; p++) begin
      case (p)
        0: begin mode_sel = 1'b0; len_sel = 9'd0;   end
        1: begin mode_sel = 1'b1; len_sel = 9'd511; end
        2: begin mode_sel = 1'b0; len_sel = 9'd511; end
        3: begin mode_sel = 1'b0; len_sel = 9'd1;   end
        4: begin mode_sel = 1'b1; len_sel = 9'd256; end
        5: begin mode_sel = 1'b0; len_sel = 9'd256; end
        default: begin
          mode_sel = ($urandom_range(0, 9) < 6);
          len_sel  = ($urandom_range(0, 1) != 0) ? 9'($urandom_range(0, 40)) : 9'($urandom);
        end
      endcase
      write_reg(CFG_CHUNKED_MODE, {8'h00, mode_sel});
      write_reg(CFG_PLAIN_LENGTH, len_sel);
      @(posedge clk_i);
      idle_on = (p % 4 != 1);
      if (p == 5) hold_go = 1'b1;
      if (p == 4) begin
        // Chunk limit: many one- and two-byte chunks in a single body.
        add_item(CMD_START, 8'($urandom));
        repeat (ChunkCap + 2) begin
          add_item(CMD_DATA, hex_char(4'($urandom_range(1, 2))));
          add_item(CMD_DATA, CHAR_LF);
          repeat (2) add_item(CMD_DATA, 8'($urandom));
          if ($urandom_range(0, 1) != 0) add_item(CMD_DATA, CHAR_LF);
          else add_item(CMD_DATA, 8'h7A);
        end
        // Byte cap reached exactly at a chunk boundary, seen at the next size line.
        add_item(CMD_START, 8'($urandom));
        add_item(CMD_DATA, 8'h31);
        add_item(CMD_DATA, 8'h30);
        add_item(CMD_DATA, 8'h30);
        add_item(CMD_DATA, CHAR_LF);
        repeat (PayloadCap) add_item(CMD_DATA, 8'($urandom));
        add_item(CMD_DATA, CHAR_CR);
        add_item(CMD_DATA, CHAR_LF);
        add_item(CMD_DATA, 8'h35);
        add_item(CMD_DATA, CHAR_LF);
      end
      if (mode_sel) begin
        // A phase may carry on the body left over from a different mode.
        add_chunked_body($urandom_range(0, 3) != 0);
        while (byte_feed.size() < PhaseTarget) add_chunked_body(1'b1);
      end else begin
        add_plain_run($urandom_range(0, 3) != 0);
      end
      drain();
      hold_go = 1'b0;
    end

    if (pending_results.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", pending_results.size()));
    end
    $display("Run covered %0d items and %0d results, %0d payload bytes kept, %0d config writes.",
             items_in, results_seen, bytes_kept, cfg_writes);
    $display("Bodies ended: %0d empty size, %0d stream end, %0d malformed, %0d limit; %0d full cycles.",
             cause_hits[CAUSE_EMPTY], cause_hits[CAUSE_EOS], cause_hits[CAUSE_BAD],
             cause_hits[CAUSE_LIMIT], full_cycles);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d failures", errors);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- http_chunked_body_decoder.f -----
design/hcbd_pkg.sv
design/hcbd_fifo.sv
design/hcbd_front.sv
design/hcbd_back.sv
design/http_chunked_body_decoder.sv
verif/http_chunked_body_decoder_tb.sv
